@@ rtl/b64d_pkg.sv @@
// Package for the base64 stream decoder.
// Holds the queue entry type, the alphabet lookup and shared constants.
package b64d_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] PadChar = 8'h3d;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            err;
    logic            last;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t ent;
  } q_push_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.bad = 1'b0;
    r.val = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.val = 6'd62;
    end else if (c == 8'h2f) begin
      r.val = 6'd63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/base64_stream_decoder.sv @@
// Top level of the base64 stream decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; depends on b64d_pkg.
//
// Decodes base64 text one character per transaction and emits one byte per
// output transaction, with an error transaction for a malformed string. A
// character is accepted every cycle while the group queue (QueueDepth
// entries) has room. The back end moves one byte a cycle from the queue
// head into the output register while that register is empty or its
// byte is taken.
module base64_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       status_o,
  output logic       last_of_string_o
);

  b64d_pkg::q_push_t push;
  b64d_pkg::grp_t    head;
  logic              q_full, q_empty, pop;

  b64d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .push_o          (push)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_byte_o      (data_byte_o),
    .status_o         (status_o),
    .last_of_string_o (last_of_string_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_full)
    else $error("group pushed into a full queue");

  a_error_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_of_string_o && data_byte_o == 8'h00)
    else $error("error transaction with data or without last flag");

  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from an empty queue");

endmodule

@@ rtl/b64d_front.sv @@
// Front end of the base64 decoder: accepts characters, tracks group state
// and pushes decoded groups or error entries. Depends on b64d_pkg.
module b64d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_string_i,
  input  logic             q_full_i,
  output b64d_pkg::q_push_t push_o
);

  logic [1:0] pos_q, pos_d;
  logic       pad2_q, pad2_d;
  logic       disc_q, disc_d;
  logic [5:0] held_q [3];
  logic [5:0] held_d [3];

  logic              accept;
  logic              is_pad;
  logic              err;
  b64d_pkg::sextet_t sx;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pad     = (char_code_i == b64d_pkg::PadChar);
  assign sx         = b64d_pkg::sextet_of(char_code_i);

  always_comb begin
    pos_d  = pos_q;
    pad2_d = pad2_q;
    disc_d = disc_q;
    held_d = held_q;
    err    = 1'b0;
    push_o = '0;
    if (accept) begin
      if (disc_q) begin
        if (end_of_string_i) begin
          disc_d = 1'b0;
          pos_d  = '0;
          pad2_d = 1'b0;
        end
      end else if (pos_q != 2'd3) begin
        if (end_of_string_i) begin
          err = 1'b1;
        end else if (is_pad) begin
          if (pos_q != 2'd2) begin
            err = 1'b1;
          end else begin
            held_d[2] = '0;
            pad2_d    = 1'b1;
            pos_d     = pos_q + 2'd1;
          end
        end else if (sx.bad) begin
          err = 1'b1;
        end else begin
          held_d[pos_q] = sx.val;
          pos_d         = pos_q + 2'd1;
        end
      end else begin
        push_o.ent.bytes[0] = {held_q[0], held_q[1][5:4]};
        push_o.ent.bytes[1] = {held_q[1][3:0], held_q[2][5:2]};
        push_o.ent.bytes[2] = {held_q[2][1:0], sx.val};
        pos_d  = '0;
        pad2_d = 1'b0;
        if (pad2_q) begin
          if (!is_pad || !end_of_string_i) begin
            err = 1'b1;
          end else begin
            push_o.valid        = 1'b1;
            push_o.ent.last_idx = 2'd0;
            push_o.ent.last     = 1'b1;
          end
        end else if (is_pad) begin
          if (!end_of_string_i) begin
            err = 1'b1;
          end else begin
            push_o.valid        = 1'b1;
            push_o.ent.last_idx = 2'd1;
            push_o.ent.last     = 1'b1;
          end
        end else if (sx.bad) begin
          err = 1'b1;
        end else begin
          push_o.valid        = 1'b1;
          push_o.ent.last_idx = 2'd2;
          push_o.ent.last     = end_of_string_i;
        end
      end
      if (err) begin
        push_o          = '0;
        push_o.valid    = 1'b1;
        push_o.ent.err  = 1'b1;
        push_o.ent.last = 1'b1;
        pos_d           = '0;
        pad2_d          = 1'b0;
        disc_d          = !end_of_string_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pad2_q <= 1'b0;
      disc_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      pad2_q <= pad2_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

@@ rtl/b64d_queue.sv @@
// Short queue of decoded groups between front and back end.
// Depends on b64d_pkg for the entry type.
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::q_push_t push_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output b64d_pkg::grp_t    head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  b64d_pkg::grp_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.ent;
    end
  end

endmodule

@@ rtl/b64d_back.sv @@
// Back end of the base64 decoder: walks the bytes of the head queue entry
// into the output register. Depends on b64d_pkg.
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  b64d_pkg::grp_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_byte_o,
  output logic           status_o,
  output logic           last_of_string_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       status_q, last_q;
  logic       load, at_end;

  assign load   = !q_empty_i && (!valid_q || out_ready_i);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  always_comb begin
    case (idx_q)
      2'd0:    data_d = head_i.bytes[0];
      2'd1:    data_d = head_i.bytes[1];
      2'd2:    data_d = head_i.bytes[2];
      default: data_d = '0;
    endcase
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= head_i.err ? 8'h00 : data_d;
      status_q <= head_i.err;
      last_q   <= at_end && head_i.last;
    end
  end

  assign out_valid_o      = valid_q;
  assign data_byte_o      = data_q;
  assign status_o         = status_q;
  assign last_of_string_o = last_q;

endmodule

@@ tb/base64_stream_decoder_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_decoder: directed and random strings,
// idle and stall phases, long output hold-off. Decoded bytes are predicted in place.
// Depends on b64d_pkg (pad character) and the decoder RTL.
module base64_stream_decoder_test;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } b64_out_t;

  typedef struct packed {
    logic       invalid;
    logic [5:0] value;
  } char_lookup_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] char_code_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_byte_o;
  logic       status_o;
  logic       last_of_string_o;

  b64_out_t    expected_bytes[$];
  logic [7:0]  pending_chars[$];
  logic [5:0]  grp_sextets[3];
  logic        grp_pad2;
  logic [1:0]  grp_pos;
  logic        dropping_rest;
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cycles = 0;

  base64_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_o     (data_byte_o),
    .status_o        (status_o),
    .last_of_string_o(last_of_string_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic char_lookup_t lookup_char(input logic [7:0] c);
    char_lookup_t r;
    r.invalid = 1'b0;
    r.value   = '0;
    if (c >= "A" && c <= "Z") r.value = 6'(c - "A");
    else if (c >= "a" && c <= "z") r.value = 6'(c - "a" + 26);
    else if (c >= "0" && c <= "9") r.value = 6'(c - "0" + 52);
    else if (c == "+") r.value = 6'd62;
    else if (c == "/") r.value = 6'd63;
    else r.invalid = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 6'd62) ? 8'("+") : 8'("/");
  endfunction

  function automatic void clear_group();
    grp_sextets[0] = '0;
    grp_sextets[1] = '0;
    grp_sextets[2] = '0;
    grp_pad2 = 1'b0;
    grp_pos = '0;
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic last);
    expected_bytes.push_back('{data: data, status: 1'b0, last: last});
  endfunction

  function automatic void reject_string(input logic eos);
    expected_bytes.push_back('{data: 8'h00, status: 1'b1, last: 1'b1});
    clear_group();
    dropping_rest = !eos;
  endfunction

  function automatic void predict_decode(input logic [7:0] c, input logic eos);
    char_lookup_t lk;
    logic [7:0]   b0, b1, b2;
    logic         is_pad;
    lk     = lookup_char(c);
    is_pad = (c == b64d_pkg::PadChar);
    if (dropping_rest) begin
      if (eos) begin
        dropping_rest = 1'b0;
        clear_group();
      end
      return;
    end
    if (grp_pos < 2'd3) begin
      if (eos) reject_string(eos);
      else if (is_pad) begin
        if (grp_pos != 2'd2) reject_string(eos);
        else begin
          grp_sextets[2] = '0;
          grp_pad2 = 1'b1;
          grp_pos = grp_pos + 2'd1;
        end
      end else if (lk.invalid) reject_string(eos);
      else begin
        grp_sextets[grp_pos] = lk.value;
        grp_pos = grp_pos + 2'd1;
      end
      return;
    end
    b0 = {grp_sextets[0], grp_sextets[1][5:4]};
    b1 = {grp_sextets[1][3:0], grp_sextets[2][5:2]};
    b2 = {grp_sextets[2][1:0], lk.value};
    if (grp_pad2) begin
      if (!is_pad || !eos) reject_string(eos);
      else begin
        push_byte(b0, 1'b1);
        clear_group();
      end
    end else if (is_pad) begin
      if (!eos) reject_string(eos);
      else begin
        push_byte(b0, 1'b0);
        push_byte(b1, 1'b1);
        clear_group();
      end
    end else if (lk.invalid) reject_string(eos);
    else begin
      push_byte(b0, 1'b0);
      push_byte(b1, 1'b0);
      push_byte(b2, eos);
      clear_group();
    end
  endfunction

  task automatic note_mismatch(input string what, input b64_out_t want, input b64_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected data %02h status %0b last %0b, got data %02h status %0b last %0b",
               what, want.data, want.status, want.last, got.data, got.status, got.last);
    end
  endtask

  always @(posedge clk_i) begin : check_output
    b64_out_t got;
    b64_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{data: data_byte_o, status: status_o, last: last_of_string_o};
      if (expected_bytes.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.status !== want.status || got.last !== want.last) begin
          note_mismatch("mismatch", want, got);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Leave valid high on return so back-to-back transactions need no second assignment.
  task automatic send_char(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    char_code_i     <= c;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    predict_decode(c, eos);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eos_last && (i == s.len() - 1));
  endtask

  task automatic send_pending();
    for (int i = 0; i < pending_chars.size(); i++) begin
      send_char(pending_chars[i], i == pending_chars.size() - 1);
    end
    pending_chars.delete();
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic queue_wellformed(input int groups);
    for (int g = 0; g < groups - 1; g++) begin
      repeat (4) pending_chars.push_back(sextet_char(6'($urandom_range(63))));
    end
    case ($urandom_range(2))
      0: repeat (4) pending_chars.push_back(sextet_char(6'($urandom_range(63))));
      1: begin
        repeat (3) pending_chars.push_back(sextet_char(6'($urandom_range(63))));
        pending_chars.push_back(b64d_pkg::PadChar);
      end
      default: begin
        repeat (2) pending_chars.push_back(sextet_char(6'($urandom_range(63))));
        repeat (2) pending_chars.push_back(b64d_pkg::PadChar);
      end
    endcase
  endtask

  task automatic send_random_string();
    int kind;
    int groups;
    int pos;
    kind   = $urandom_range(99);
    groups = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 2);
    queue_wellformed(groups);
    if (kind < 60) begin
    end else if (kind < 72) begin
      repeat ($urandom_range(1, 3)) if (pending_chars.size() > 1) void'(pending_chars.pop_back());
    end else if (kind < 88) begin
      pos = $urandom_range(pending_chars.size() - 1);
      pending_chars[pos] = $urandom_range(1) ? b64d_pkg::PadChar : 8'($urandom_range(255));
    end else begin
      pending_chars.delete();
      repeat ($urandom_range(1, 6)) pending_chars.push_back(8'($urandom_range(255)));
    end
    send_pending();
  endtask

  task automatic apply_reset();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    char_code_i     = '0;
    end_of_string_i = 1'b0;
    out_ready_i     = 1'b0;
    clear_group();
    dropping_rest = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
  endtask

  task automatic test_wellformed_strings();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("////AAAz9+A=", 1'b1);
    send_text("//==", 1'b1);
    wait_for_drain();
  endtask

  task automatic test_malformed_strings();
    send_char(8'hff, 1'b0);
    send_text("=", 1'b1);
    send_text("A=B", 1'b1);
    send_text("AB=C", 1'b1);
    send_text("ABC=x", 1'b1);
    send_text("ABC", 1'b1);
    send_text("=", 1'b1);
    send_text("QQ==", 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = chars_sent + 55;
    while (chars_sent < target) send_random_string();
    wait_for_drain();
  endtask

  task automatic test_output_holdoff();
    int unsigned target;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 300;
    target = chars_sent + 40;
    while (chars_sent < target) begin
      queue_wellformed($urandom_range(1, 3));
      send_pending();
    end
    wait_for_drain();
    queue_wellformed(2);
    send_pending();
    wait_for_drain();
  endtask

  initial begin
    apply_reset();
    test_wellformed_strings();
    test_malformed_strings();
    test_random_traffic(0, 0);
    test_random_traffic(55, 0);
    test_random_traffic(0, 55);
    test_random_traffic(10, 10);
    test_output_holdoff();
    wait_for_drain();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
